// ----- rtl/lsra_pkg.sv -----
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants of the linear-scan register allocator.
// Holds the transaction layouts, the result kind codes and the fixed widths.
// ----------------------------------------------------------------------------
package lsra_pkg;

	// Fixed field widths of the transactions.
	localparam int VALUE_W  = 12;
	localparam int INDEX_W  = 16;
	localparam int REG_W    = 4;
	localparam int OFFSET_W = 17;
	localparam int AREA_W   = 16;

	// Spill slots start at this many bytes below the frame and step by a word.
	localparam int SPILL_BASE = 16;

	// Depth of the result queue; it must take two results from one range.
	localparam int QUEUE_DEPTH = 4;

	// Result kind codes.
	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_SPILL = 2'd1,
		KIND_EVICT = 2'd2
	} kind_t;

	// One live range as it is held after the input register.
	typedef struct packed {
		logic [VALUE_W-1:0] ssa_id;
		logic [INDEX_W-1:0] live_start;
		logic [INDEX_W-1:0] live_end;
		logic               last_range;
	} range_t;

	// One result transaction.
	typedef struct packed {
		kind_t                      kind;
		logic [VALUE_W-1:0]         value;
		logic [REG_W-1:0]           reg_num;
		logic signed [OFFSET_W-1:0] offset;
		logic [AREA_W-1:0]          area;
		logic                       last;
	} result_t;

endpackage

// ----- rtl/lsra_req_if.sv -----
// ----------------------------------------------------------------------------
// lsra_req_if: live-range request channel.
// Valid/ready handshake carrying one live range per transaction.
// ----------------------------------------------------------------------------
interface lsra_req_if import lsra_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] ssa_id;
	logic [INDEX_W-1:0] live_start;
	logic [INDEX_W-1:0] live_end;
	logic               last_range;

	modport source (output valid, ssa_id, live_start, live_end, last_range, input ready);
	modport sink (input valid, ssa_id, live_start, live_end, last_range, output ready);

endinterface

// ----- rtl/lsra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lsra_rsp_if: allocation result channel.
// Valid/ready handshake carrying one allocation result per transaction.
// ----------------------------------------------------------------------------
interface lsra_rsp_if import lsra_pkg::*; ();

	logic                       valid;
	logic                       ready;
	kind_t                      kind;
	logic [VALUE_W-1:0]         result_value;
	logic [REG_W-1:0]           register_number;
	logic signed [OFFSET_W-1:0] frame_offset;
	logic [AREA_W-1:0]          spill_area;
	logic                       last_of_run;

	modport source (
		output valid, kind, result_value, register_number, frame_offset, spill_area,
		       last_of_run,
		input  ready
	);
	modport sink (
		input  valid, kind, result_value, register_number, frame_offset, spill_area,
		       last_of_run,
		output ready
	);

endinterface

// ----- rtl/lsra_alloc.sv -----
// ----------------------------------------------------------------------------
// lsra_alloc: slot table, spill counter and combinational allocation decision.
// Expires old ranges, picks a free slot or the latest-ending victim, and
// forms the one or two results of a range.
// ----------------------------------------------------------------------------
module lsra_alloc import lsra_pkg::*; #(
	parameter int NUM_SLOTS      = 7,
	parameter int FIRST_REGISTER = 9,
	parameter int SPILL_DEPTH    = 4096,
	parameter int INDEX_BITS     = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  range_t  item,
	output result_t res0,
	output result_t res1,
	output logic    two
);

	localparam int IW = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(SPILL_DEPTH + 1);

	logic [NUM_SLOTS-1:0] busy_q;
	logic [IW-1:0]        expiry_q [NUM_SLOTS];
	logic [VALUE_W-1:0]   holder_q [NUM_SLOTS];
	logic [CW-1:0]        spill_cnt_q;

	logic [IW-1:0]         fu, lu;
	logic [NUM_SLOTS-1:0]  live;
	logic [NUM_SLOTS-1:0]  busy_next;
	logic [NUM_SLOTS-1:0]  best_oh;
	logic                  any_free;
	logic [SW-1:0]         free_idx, best_idx, target;
	logic [IW-1:0]         best_exp;
	logic [VALUE_W-1:0]    best_holder;
	logic                  spill_new;
	logic                  at_cap;
	logic [CW-1:0]         slot_idx, cnt_next;
	logic [CW:0]           cnt_round;
	logic [OFFSET_W-1:0]   off_take, off_none;
	logic [AREA_W-1:0]     area;
	logic [REG_W-1:0]      reg_num;

	// Expire ranges that ended before this one starts.
	always_comb begin
		fu = item.live_start[IW-1:0];
		lu = item.live_end[IW-1:0];
		for (int i = 0; i < NUM_SLOTS; i++) begin
			live[i] = busy_q[i] && !(expiry_q[i] < fu);
		end
		any_free = ~&live;
	end

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!live[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	// Latest expiry, lowest index on a tie, as one layer of pairwise compares.
	always_comb begin
		best_idx    = '0;
		best_exp    = '0;
		best_holder = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			best_oh[i] = 1'b1;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				if (j < i) begin
					best_oh[i] = best_oh[i] && (expiry_q[i] > expiry_q[j]);
				end else if (j > i) begin
					best_oh[i] = best_oh[i] && (expiry_q[i] >= expiry_q[j]);
				end
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (best_oh[i]) begin
				best_idx    = best_idx | SW'(i);
				best_exp    = best_exp | expiry_q[i];
				best_holder = best_holder | holder_q[i];
			end
		end
	end

	// Decision, spill slot, register number and the next busy bits.
	always_comb begin
		spill_new = !any_free && (lu < best_exp);
		two       = !any_free && !spill_new;
		target    = any_free ? free_idx : best_idx;
		at_cap    = (spill_cnt_q == CW'(SPILL_DEPTH));
		slot_idx  = at_cap ? CW'(SPILL_DEPTH - 1) : spill_cnt_q;
		cnt_next  = (!any_free && !at_cap) ? spill_cnt_q + CW'(1) : spill_cnt_q;
		cnt_round = {1'b0, cnt_next} + (CW + 1)'(cnt_next[0]);
		off_none  = OFFSET_W'(0) - OFFSET_W'(SPILL_BASE);
		off_take  = off_none - OFFSET_W'({slot_idx, 3'b000});
		area      = AREA_W'({cnt_round, 3'b000});
		reg_num   = REG_W'(6'(FIRST_REGISTER) + 6'(target));
		busy_next = live;
		if (!spill_new) begin
			busy_next[target] = 1'b1;
		end
	end

	// Result forming.
	always_comb begin
		res0.kind    = KIND_REG;
		res0.value   = item.ssa_id;
		res0.reg_num = reg_num;
		res0.offset  = $signed(off_none);
		res0.area    = area;
		res0.last    = 1'b1;
		if (spill_new) begin
			res0.kind    = KIND_SPILL;
			res0.reg_num = '0;
			res0.offset  = $signed(off_take);
		end else if (two) begin
			res0.kind    = KIND_EVICT;
			res0.value   = best_holder;
			res0.reg_num = '0;
			res0.offset  = $signed(off_take);
			res0.last    = 1'b0;
		end
		res1.kind    = KIND_REG;
		res1.value   = item.ssa_id;
		res1.reg_num = reg_num;
		res1.offset  = $signed(off_none);
		res1.area    = area;
		res1.last    = 1'b1;
	end

	// Busy bits and spill counter; the last range of a function clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			spill_cnt_q <= '0;
		end else if (fire) begin
			if (item.last_range) begin
				busy_q      <= '0;
				spill_cnt_q <= '0;
			end else begin
				busy_q      <= busy_next;
				spill_cnt_q <= cnt_next;
			end
		end
	end

	// Slot contents are only read while the slot is busy.
	always_ff @(posedge clk) begin
		if (fire && !spill_new) begin
			expiry_q[target] <= lu;
			holder_q[target] <= item.ssa_id;
		end
	end

	// With every slot busy exactly one victim is chosen.
	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !any_free |-> $onehot(best_oh))
		else $error("victim selection is not one-hot");

	// The spill counter saturates at the number of spill slots.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		spill_cnt_q <= CW'(SPILL_DEPTH))
		else $error("spill counter ran past its limit");

	// An eviction only happens when every slot is still busy.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && two |-> &live)
		else $error("eviction while a slot was free");

endmodule

// ----- rtl/lsra_result_queue.sv -----
// ----------------------------------------------------------------------------
// lsra_result_queue: small result FIFO feeding the response channel.
// Takes one or two results per cycle while it has room and hands out one per transaction.
// ----------------------------------------------------------------------------
module lsra_result_queue import lsra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              push_two,
	input  result_t           res0,
	input  result_t           res1,
	output logic              room,
	lsra_rsp_if.source        rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	result_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [PW:0]   count_q;
	logic          pop;
	logic [PW:0]   push_n;

	// Room for the largest burst of one range.
	assign room   = (count_q <= (PW + 1)'(QUEUE_DEPTH - 2));
	assign pop    = rsp.valid && rsp.ready;
	assign push_n = push ? (push_two ? (PW + 1)'(2) : (PW + 1)'(1)) : '0;

	// Head of queue drives the response channel.
	always_comb begin
		rsp.valid           = (count_q != '0);
		rsp.kind            = mem_q[head_q].kind;
		rsp.result_value    = mem_q[head_q].value;
		rsp.register_number = mem_q[head_q].reg_num;
		rsp.frame_offset    = mem_q[head_q].offset;
		rsp.spill_area      = mem_q[head_q].area;
		rsp.last_of_run     = mem_q[head_q].last;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PW'(1);
			end
			tail_q  <= tail_q + PW'(push_n);
			count_q <= count_q + push_n - (PW + 1)'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= res0;
			if (push_two) begin
				mem_q[tail_q + PW'(1)] <= res1;
			end
		end
	end

	// The fill count never exceeds the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW + 1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// A push only happens when the queue announced room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed without room");

	// A transaction only leaves a queue that holds something.
	a_pop_filled: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("result popped from an empty queue");

endmodule

// ----- rtl/linear_scan_register_allocator.sv -----
// ----------------------------------------------------------------------------
// linear_scan_register_allocator: linear-scan allocation of live ranges.
//
//   channel | dir | per transaction
//   --------+-----+-------------------------------------------------------
//   req     | in  | one live range: ssa_id, live_start, live_end, last_range
//   rsp     | out | one result: kind, value, register, spill slot, area
//
// One range is taken per cycle while the result queue has room. The first
// result of a range passes the input register and the slot-table decision,
// is offered on rsp from the result queue and leaves once rsp is ready.
// An evicting range gives two results, which leave one after the other.
// Reset clears the busy bits and spill counter at once; a stalled rsp channel
// stalls req only once the queue lacks room.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator import lsra_pkg::*; #(
	parameter int NUM_SLOTS      = 7,
	parameter int FIRST_REGISTER = 9,
	parameter int SPILL_DEPTH    = 4096,
	parameter int INDEX_BITS     = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lsra_req_if.sink   req,
	lsra_rsp_if.source rsp
);

	logic    valid_s1;
	range_t  item_s1;
	logic    room;
	logic    advance;
	result_t res0, res1;
	logic    two;

	// The input register drains into the queue whenever it has room.
	assign advance   = valid_s1 && room;
	assign req.ready = !valid_s1 || room;

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.ssa_id     <= req.ssa_id;
			item_s1.live_start <= req.live_start;
			item_s1.live_end   <= req.live_end;
			item_s1.last_range <= req.last_range;
		end
	end

	// Allocation decision and slot table.
	lsra_alloc #(
		.NUM_SLOTS      (NUM_SLOTS),
		.FIRST_REGISTER (FIRST_REGISTER),
		.SPILL_DEPTH    (SPILL_DEPTH),
		.INDEX_BITS     (INDEX_BITS)
	) u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res0   (res0),
		.res1   (res1),
		.two    (two)
	);

	// Result queue toward the response channel.
	lsra_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.push_two (two),
		.res0     (res0),
		.res1     (res1),
		.room     (room),
		.rsp      (rsp)
	);

endmodule
